FILE: sv/clc_pkg.sv
package clc_pkg;

   localparam int CARD_W       = 54;
   localparam int DIGIT_W      = 4;
   localparam int CELLS        = 17;
   localparam int GROUP_W      = 3;
   localparam int CONV_STEPS   = CARD_W / GROUP_W;
   localparam int STEP_W       = $clog2(CONV_STEPS);
   localparam int COUNT_W      = 5;
   localparam int PART_SIZE    = 4;
   localparam int PARTS        = (CELLS + PART_SIZE - 1) / PART_SIZE;
   localparam int TERM_W       = 4;
   localparam int PART_W       = 6;
   localparam int SUM_W        = 8;
   localparam int LEAD_W       = 7;

   localparam int DD_THRESHOLD = 5;
   localparam int DD_OFFSET    = 3;
   localparam int DIGIT_BASE   = 10;
   localparam int DIGIT_MAX    = 9;
   localparam int SUM_MAX_TENS = (CELLS * DIGIT_MAX) / DIGIT_BASE;

   localparam int LEN_SHORT    = 13;
   localparam int LEN_MID      = 15;
   localparam int LEN_LONG     = 16;
   localparam int PREFIX_A_LO  = 34;
   localparam int PREFIX_A_HI  = 37;
   localparam int PREFIX_M_MIN = 51;
   localparam int PREFIX_M_MAX = 55;
   localparam int PREFIX_V_MIN = 40;
   localparam int PREFIX_V_MAX = 49;

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef enum logic [1:0] {
      CLASS_INVALID = 2'd0,
      CLASS_A       = 2'd1,
      CLASS_M       = 2'd2,
      CLASS_V       = 2'd3
   } card_class_type;

   function automatic logic [TERM_W-1:0] luhn_term(digit_type d, logic doubled);
      logic [DIGIT_W:0] p;
      p = {d, 1'b0};
      if (!doubled) begin
         return TERM_W'(d);
      end else if (p >= (DIGIT_W + 1)'(DIGIT_BASE)) begin
         return TERM_W'(p - (DIGIT_W + 1)'(DIGIT_MAX));
      end else begin
         return TERM_W'(p);
      end
   endfunction

   function automatic logic sum_mod10_zero(logic [SUM_W-1:0] s);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k <= SUM_MAX_TENS; k++) begin
         if (s == SUM_W'(k * DIGIT_BASE)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

FILE: sv/clc_if.sv
interface clc_req_if
   import clc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CARD_W-1:0] card_number;

   modport source (output valid, output card_number, input ready);
   modport sink   (input valid, input card_number, output ready);
endinterface

interface clc_rsp_if
   import clc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [1:0]         card_class;
   logic               luhn_ok;
   logic [COUNT_W-1:0] digit_count;

   modport source (output valid, output card_class, output luhn_ok, output digit_count,
                   input ready);
   modport sink   (input valid, input card_class, input luhn_ok, input digit_count,
                   output ready);
endinterface

FILE: sv/clc_cell.sv
module clc_cell
   import clc_pkg::*;
(
   input  logic               clock,
   input  logic               clear,
   input  logic               shift,
   input  logic [GROUP_W-1:0] bits_in,
   output logic [GROUP_W-1:0] bits_out,
   output digit_type          digit
);

   digit_type digit_ff;
   digit_type digit_in;

   always_comb begin
      digit_type v;
      v = digit_ff;
      bits_out = '0;
      for (int k = GROUP_W - 1; k >= 0; k--) begin
         if (v >= DIGIT_W'(DD_THRESHOLD)) begin
            v = v + DIGIT_W'(DD_OFFSET);
         end
         bits_out[k] = v[DIGIT_W-1];
         v = {v[DIGIT_W-2:0], bits_in[k]};
      end
      digit_in = v;
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         digit_ff <= '0;
      end else if (shift) begin
         digit_ff <= digit_in;
      end
   end

   assign digit = digit_ff;

endmodule

FILE: sv/card_number_luhn_classifier_core.sv
// An accepted number is shifted into the digit cell row three bits at a time in the CONV
// state, then the PART state registers the partial sums and the FIN state classifies it.
// The cell row holds one number at a time; a new number is taken only in the IDLE state.
// The output register lets a new number enter while the previous result waits.
// Reset: synchronous, active high; clears the controller and the result valid flag.
module card_number_luhn_classifier_core
   import clc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   clc_req_if.sink   req_port,
   clc_rsp_if.source rsp_port
);

   typedef enum logic [1:0] {
      IDLE,
      CONV,
      PART,
      FIN
   } state_type;

   state_type            state_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 rsp_valid_ff;
   card_class_type       rsp_class_ff;
   logic                 rsp_luhn_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic [CARD_W-1:0]    num_ff;
   logic [PART_W-1:0]    parts_ff [PARTS];
   logic [COUNT_W-1:0]   count_ff;
   logic [LEAD_W-1:0]    lead_ff;

   logic                 req_xfer;
   logic                 cell_shift;
   logic [GROUP_W-1:0]   carry [CELLS+1];
   digit_type            digits [CELLS];
   digit_type            lo_src [CELLS];

   logic [PART_W-1:0]    parts_in [PARTS];
   logic [COUNT_W-1:0]   count_in;
   logic [LEAD_W-1:0]    lead_in;
   logic [SUM_W-1:0]     total;
   logic                 luhn_ok;
   logic                 len_ok;
   card_class_type       class_in;

   assign req_xfer   = req_port.valid && req_port.ready;
   assign cell_shift = (state_ff == CONV);
   assign carry[0]   = num_ff[CARD_W-1 -: GROUP_W];

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      clc_cell u_cell (
         .clock    (clock),
         .clear    (req_xfer),
         .shift    (cell_shift),
         .bits_in  (carry[i]),
         .bits_out (carry[i+1]),
         .digit    (digits[i])
      );
      if (i == 0) begin : g_lo_zero
         assign lo_src[i] = '0;
      end else begin : g_lo_next
         assign lo_src[i] = digits[i-1];
      end
   end

   always_comb begin
      for (int g = 0; g < PARTS; g++) begin
         parts_in[g] = '0;
         for (int j = 0; j < PART_SIZE; j++) begin
            if (g * PART_SIZE + j < CELLS) begin
               parts_in[g] = parts_in[g] + PART_W'(luhn_term(digits[g * PART_SIZE + j],
                                                             ((g * PART_SIZE + j) % 2) == 1));
            end
         end
      end
   end

   always_comb begin
      digit_type hi;
      digit_type lo;
      hi       = '0;
      lo       = '0;
      count_in = '0;
      for (int i = 0; i < CELLS; i++) begin
         if (digits[i] != '0) begin
            count_in = COUNT_W'(i + 1);
            hi       = digits[i];
            lo       = lo_src[i];
         end
      end
      lead_in = LEAD_W'({hi, 3'b000}) + LEAD_W'({hi, 1'b0}) + LEAD_W'(lo);
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < PARTS; g++) begin
         total = total + SUM_W'(parts_ff[g]);
      end
      luhn_ok = sum_mod10_zero(total);
      len_ok  = (count_ff == COUNT_W'(LEN_SHORT)) || (count_ff == COUNT_W'(LEN_MID))
             || (count_ff == COUNT_W'(LEN_LONG));
      class_in = CLASS_INVALID;
      if (len_ok && luhn_ok) begin
         if ((lead_ff == LEAD_W'(PREFIX_A_LO)) || (lead_ff == LEAD_W'(PREFIX_A_HI))) begin
            class_in = CLASS_A;
         end else if ((lead_ff >= LEAD_W'(PREFIX_M_MIN)) &&
                      (lead_ff <= LEAD_W'(PREFIX_M_MAX))) begin
            class_in = CLASS_M;
         end else if ((lead_ff >= LEAD_W'(PREFIX_V_MIN)) &&
                      (lead_ff <= LEAD_W'(PREFIX_V_MAX))) begin
            class_in = CLASS_V;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         num_ff <= req_port.card_number;
      end else if (state_ff == CONV) begin
         num_ff <= {num_ff[CARD_W-GROUP_W-1:0], {GROUP_W{1'b0}}};
      end
      if (state_ff == PART) begin
         parts_ff <= parts_in;
         count_ff <= count_in;
         lead_ff  <= lead_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == FIN) && (!rsp_valid_ff || rsp_port.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_xfer) begin
                  step_ff  <= '0;
                  state_ff <= CONV;
               end
            end
            CONV: begin
               if (step_ff == STEP_W'(CONV_STEPS - 1)) begin
                  state_ff <= PART;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            PART: begin
               state_ff <= FIN;
            end
            FIN: begin
               if (!rsp_valid_ff || rsp_port.ready) begin
                  rsp_class_ff <= class_in;
                  rsp_luhn_ff  <= luhn_ok;
                  rsp_count_ff <= count_ff;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_port.ready       = (state_ff == IDLE);
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.card_class  = rsp_class_ff;
   assign rsp_port.luhn_ok     = rsp_luhn_ff;
   assign rsp_port.digit_count = rsp_count_ff;

   a_busy_after_xfer : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_port.ready)
      else $error("input taken while a number is in conversion");

   a_no_digit_overflow : assert property (@(posedge clock) disable iff (reset)
      (state_ff == CONV) |-> (carry[CELLS] == '0))
      else $error("digit cell row overflow");

   a_step_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == CONV) |-> (step_ff < STEP_W'(CONV_STEPS)))
      else $error("conversion step counter out of range");

   a_class_needs_check : assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && (rsp_port.card_class != CLASS_INVALID)) |->
         (rsp_port.luhn_ok && ((rsp_port.digit_count == COUNT_W'(LEN_SHORT)) ||
                               (rsp_port.digit_count == COUNT_W'(LEN_MID)) ||
                               (rsp_port.digit_count == COUNT_W'(LEN_LONG)))))
      else $error("class given to a number that fails length or check");

endmodule
